FILE: src/utf8_stream_decoder_assert.svh
// assertion macros for the utf8 stream decoder checker
// no dependencies; included by the checker file
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// plain property check on the rising clock edge, quiet while in reset
`define U8SD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// a stalled beat keeps the given signal unchanged on the next edge
`define U8SD_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> $stable(sig)) \
    else $error(msg);

`endif

FILE: src/utf8sd_pkg.sv
// shared types, constants and decode functions of the utf8 stream decoder
// no dependencies; imported by the front end, queue, back end and top modules
package utf8sd_pkg;

  localparam int unsigned MaxRes     = 4;
  localparam int unsigned IdxW       = $clog2(MaxRes);
  localparam int unsigned QueueDepth = 2;

  localparam logic [20:0] ReplCp   = 21'h00FFFD;
  localparam logic [7:0]  ContMask = 8'hC0;
  localparam logic [7:0]  ContTag  = 8'h80;

  // one decoded code point
  typedef struct packed {
    logic [20:0] cp;
    logic        repl;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [2:0]        cnt;
    logic              last;
  } step_t;

  // decode outcome: results plus what remains held
  typedef struct packed {
    step_t      rec;
    logic [2:0] start;
    logic [1:0] rest;
  } dec_t;

  // sequence length from the lead byte, zero for an invalid lead
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7]) len = 3'd1;
    else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  // code point from a lead and its continuation bytes
  function automatic logic [20:0] assemble(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] len);
    logic [20:0] v;
    case (len)
      3'd2:    v = {10'b0, b0[4:0], b1[5:0]};
      3'd3:    v = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
      default: v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    return v;
  endfunction

  // walk the held bytes plus the new one, up to MaxRes results per call
  function automatic dec_t decode_step(input logic [3:0][7:0] bytes,
                                       input logic [2:0] n, input logic last);
    dec_t        r;
    logic [2:0]  start, k, need, avail, have, pos;
    logic [2:0]  p1, p2, p3;
    logic [7:0]  lead;
    logic        bad, done, emit, is_repl;
    logic [20:0] val;
    r     = '0;
    start = '0;
    k     = '0;
    done  = 1'b0;
    for (int it = 0; it < MaxRes; it++) begin
      if (!done && start < n) begin
        lead  = bytes[start[1:0]];
        avail = n - start;
        need  = seq_len(lead);
        have  = (avail < need) ? avail : need;
        bad   = 1'b0;
        for (int j = 1; j < MaxRes; j++) begin
          pos = start + 3'(j);
          if (3'(j) < have && (bytes[pos[1:0]] & ContMask) != ContTag) bad = 1'b1;
        end
        p1      = start + 3'd1;
        p2      = start + 3'd2;
        p3      = start + 3'd3;
        emit    = 1'b1;
        is_repl = 1'b0;
        val     = {13'b0, lead};
        if (need == 3'd1) begin
          start = start + 3'd1;
        end else if (need == 3'd0 || bad) begin
          is_repl = 1'b1;
          val     = ReplCp;
          start   = start + 3'd1;
        end else if (avail >= need) begin
          val   = assemble(lead, bytes[p1[1:0]], bytes[p2[1:0]], bytes[p3[1:0]], need);
          start = start + need;
        end else if (last) begin
          // cut off by the end of the text
          is_repl = 1'b1;
          val     = ReplCp;
          start   = start + 3'd1;
        end else begin
          emit = 1'b0;
          done = 1'b1;
        end
        if (emit) begin
          r.rec.res[k[IdxW-1:0]].cp   = val;
          r.rec.res[k[IdxW-1:0]].repl = is_repl;
          k = k + 3'd1;
        end
      end else begin
        done = 1'b1;
      end
    end
    r.rec.cnt  = k;
    r.rec.last = last;
    r.start    = start;
    r.rest     = 2'(n - start);
    return r;
  endfunction

endpackage

FILE: src/utf8sd_if.sv
// valid/ready channel interfaces: byte input and code point output
// no dependencies
interface utf8sd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_last;

  modport source (output valid, output in_byte, output text_last, input ready);
  modport sink   (input valid, input in_byte, input text_last, output ready);
endinterface

interface utf8sd_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        is_replacement;
  logic        run_last;
  logic        text_end;

  modport source (output valid, output code_point, output is_replacement,
                  output run_last, output text_end, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input run_last, input text_end, output ready);
endinterface

FILE: src/utf8sd_front.sv
// front end: takes one byte a beat, keeps pending bytes, decodes a whole step
// depends on utf8sd_pkg and utf8sd_byte_if
module utf8sd_front import utf8sd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8sd_byte_if.sink   byte_i,
  input  logic          full_i,
  output logic          push_o,
  output step_t         rec_o
);

  logic [1:0]       cnt_q, cnt_d;
  logic [2:0][7:0]  pend_q, pend_d;
  logic [3:0][7:0]  bytes;
  logic [2:0]       n;
  logic             accept;
  dec_t             dec;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && byte_i.ready;

  // held bytes followed by the new beat
  always_comb begin
    bytes[0] = (cnt_q == 2'd0) ? byte_i.in_byte : pend_q[0];
    bytes[1] = (cnt_q == 2'd1) ? byte_i.in_byte : (cnt_q > 2'd1) ? pend_q[1] : 8'h00;
    bytes[2] = (cnt_q == 2'd2) ? byte_i.in_byte : (cnt_q == 2'd3) ? pend_q[2] : 8'h00;
    bytes[3] = (cnt_q == 2'd3) ? byte_i.in_byte : 8'h00;
  end

  assign n   = {1'b0, cnt_q} + 3'd1;
  assign dec = decode_step(bytes, n, byte_i.text_last);

  // bytes left over shift down to the front
  always_comb begin
    logic [2:0] pos;
    pos = '0;
    for (int j = 0; j < 3; j++) begin
      pos       = dec.start + 3'(j);
      pend_d[j] = bytes[pos[1:0]];
    end
  end

  assign cnt_d  = dec.rest;
  assign push_o = accept && (dec.rec.cnt != 3'd0);
  assign rec_o  = dec.rec;

  // pending count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // pending bytes, read only below the count
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

endmodule

FILE: src/utf8sd_queue.sv
// short queue of decoded steps between front and back end
// depends on utf8sd_pkg
module utf8sd_queue import utf8sd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t rec_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output step_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  step_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule

FILE: src/utf8sd_back.sv
// back end: sends the results of each queued step, one beat per cycle while cp_o is ready
// depends on utf8sd_pkg and utf8sd_cp_if
module utf8sd_back import utf8sd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  step_t        head_i,
  output logic         pop_o,
  utf8sd_cp_if.source  cp_o
);

  logic [IdxW-1:0] idx_q;
  logic            vld_q;
  logic [20:0]     cp_q;
  logic            repl_q, run_last_q, text_end_q;
  logic            load, last_res;

  assign last_res = ({1'b0, idx_q} == head_i.cnt - 3'd1);
  assign load     = valid_i && (!vld_q || cp_o.ready);
  assign pop_o    = load && last_res;

  // output valid and position within the step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= last_res ? '0 : idx_q + 1'b1;
      end else if (cp_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q       <= head_i.res[idx_q].cp;
      repl_q     <= head_i.res[idx_q].repl;
      run_last_q <= last_res;
      text_end_q <= last_res && head_i.last;
    end
  end

  assign cp_o.valid          = vld_q;
  assign cp_o.code_point     = cp_q;
  assign cp_o.is_replacement = repl_q;
  assign cp_o.run_last       = run_last_q;
  assign cp_o.text_end       = text_end_q;

endmodule

FILE: src/utf8_stream_decoder.sv
// utf8 stream decoder: byte channel in, code point channel out
// depends on utf8sd_pkg, utf8sd_if, utf8sd_front, utf8sd_queue, utf8sd_back
//
// byte_i carries one byte of utf-8 text a beat, text_last marks the final byte.
// cp_o carries decoded code points; a bad lead, stray or bad continuation, or a
// sequence cut off by text_last gives U+FFFD with is_replacement set, and the
// bytes after that lead are examined again. run_last marks the final result of
// one input byte, text_end the final result of the text.
// a byte is decoded in the front end together with up to three held bytes;
// a byte that only extends a sequence gives no beat. results pass through the
// step queue and the output register before they appear on cp_o.
// the front end takes a byte every cycle while the step queue has room; the
// back end sends one result per cycle while cp_o is ready, one beat for each
// result of a byte, and the queue depth sets how far the front runs ahead.
// reset clears the held-byte count, the queue and the output valid and position.
// while cp_o stalls, the output beat holds, the queue fills, then byte_i ready
// drops until an entry drains.
module utf8_stream_decoder import utf8sd_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8sd_byte_if.sink   byte_i,
  utf8sd_cp_if.source   cp_o
);

  logic  push, full, pop, head_vld;
  step_t rec, head;

  utf8sd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .full_i (full),
    .push_o (push),
    .rec_o  (rec)
  );

  utf8sd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_vld),
    .head_o  (head)
  );

  utf8sd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_vld),
    .head_i  (head),
    .pop_o   (pop),
    .cp_o    (cp_o)
  );

endmodule

FILE: src/utf8sd_checker.sv
// port-level checks on the code point channel of the utf8 stream decoder
// depends on utf8_stream_decoder_assert.svh; bound to utf8_stream_decoder
`include "utf8_stream_decoder_assert.svh"

module utf8sd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [20:0] code_point_i,
  input logic        is_replacement_i,
  input logic        run_last_i,
  input logic        text_end_i
);

  // a stalled beat stays up
  `U8SD_ASSERT(a_valid_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i, "stalled beat dropped")

  // a stalled beat keeps its code point
  `U8SD_ASSERT_HOLD(a_cp_hold, clk_i, rst_ni, out_valid_i, out_ready_i, code_point_i, "stalled code point changed")

  // replacement beats always carry U+FFFD
  `U8SD_ASSERT(a_repl_value, clk_i, rst_ni, (out_valid_i && is_replacement_i) |-> (code_point_i == 21'h00FFFD), "replacement without U+FFFD")

  // end of text only on the last result of a byte
  `U8SD_ASSERT(a_end_on_last, clk_i, rst_ni, (out_valid_i && text_end_i) |-> run_last_i, "text end on an inner result")

endmodule

bind utf8_stream_decoder utf8sd_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (cp_o.valid),
  .out_ready_i      (cp_o.ready),
  .code_point_i     (cp_o.code_point),
  .is_replacement_i (cp_o.is_replacement),
  .run_last_i       (cp_o.run_last),
  .text_end_i       (cp_o.text_end)
);
